>>> hw/rtl/tdg_pkg.sv
// ----------------------------------------------------------------------------
// tdg_pkg
// shared types and constants of the torque oscillation guard
// ----------------------------------------------------------------------------
package tdg_pkg;

	localparam int TORQUE_W = 16;
	localparam int CFG_W    = 31;
	localparam int CFG_IDX_W = 2;

	typedef logic signed [TORQUE_W-1:0] sample_t;

	// register indexes of the config port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AMPLITUDE_THRESHOLD      = 2'd0,
		CFG_SIGN_CHANGE_MIN          = 2'd1,
		CFG_HOLD_TICKS               = 2'd2,
		CFG_COMMAND_CHANGE_THRESHOLD = 2'd3
	} cfg_idx_t;

	localparam logic [15:0] AMP_THR_RST  = 16'd2560;
	localparam logic [5:0]  SC_MIN_RST   = 6'd15;
	localparam logic [15:0] HOLD_RST     = 16'd1000;
	localparam logic [30:0] CMD_THR_RST  = 31'd66;

	// control for the window scan unit
	typedef struct packed {
		logic init;
		logic step;
	} scan_ctl_t;

endpackage

>>> hw/rtl/tdg_if.sv
// ----------------------------------------------------------------------------
// tdg_if
// valid/ready channels for command items and torque result items
// ----------------------------------------------------------------------------
interface tdg_in_if;
	logic                   valid;
	logic                   ready;
	tdg_pkg::sample_t       torque_in;
	logic signed [31:0]     yaw_command;
	logic signed [31:0]     launch_command;
	logic                   command_invalid;

	modport source (output valid, torque_in, yaw_command, launch_command,
		command_invalid, input ready);
	modport sink (input valid, torque_in, yaw_command, launch_command,
		command_invalid, output ready);
endinterface

interface tdg_out_if;
	logic                   valid;
	logic                   ready;
	tdg_pkg::sample_t       torque_out;
	logic                   hold_active;
	logic                   oscillation_found;

	modport source (output valid, torque_out, hold_active, oscillation_found,
		input ready);
	modport sink (input valid, torque_out, hold_active, oscillation_found,
		output ready);
endinterface

>>> hw/rtl/tdg_cell.sv
// ----------------------------------------------------------------------------
// tdg_cell
// one torque sample of the window chain, takes its right neighbor when enabled
// ----------------------------------------------------------------------------
module tdg_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  tdg_pkg::sample_t nbr,
	output tdg_pkg::sample_t sample
);

	tdg_pkg::sample_t sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (en) begin
			sample_q <= nbr;
		end
	end

	assign sample = sample_q;

endmodule

>>> hw/rtl/tdg_scan.sv
// ----------------------------------------------------------------------------
// tdg_scan
// watches the head of the rotating chain: sign changes, min and max
// ----------------------------------------------------------------------------
module tdg_scan #(
	parameter int WINDOW = 16
) (
	input  logic                       clk,
	input  tdg_pkg::scan_ctl_t         ctl,
	input  tdg_pkg::sample_t           head,
	output logic [$clog2(WINDOW)-1:0]  changes,
	output logic [16:0]                spread
);

	localparam int CW = $clog2(WINDOW);

	tdg_pkg::sample_t prev_q;
	tdg_pkg::sample_t lo_q;
	tdg_pkg::sample_t hi_q;
	logic [CW-1:0]    cnt_q;
	logic             flip;

	// strict sign change, a zero sample never counts
	assign flip = ((prev_q < 0) && (head > 0)) || ((prev_q > 0) && (head < 0));

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			prev_q <= head;
			lo_q   <= head;
			hi_q   <= head;
			cnt_q  <= '0;
		end else if (ctl.step) begin
			prev_q <= head;
			if (head < lo_q) lo_q <= head;
			if (head > hi_q) hi_q <= head;
			if (flip) cnt_q <= cnt_q + CW'(1);
		end
	end

	assign changes = cnt_q;
	assign spread  = {hi_q[15], hi_q} - {lo_q[15], lo_q};

endmodule

>>> hw/rtl/torque_oscillation_deadzone_guard_core.sv
// ----------------------------------------------------------------------------
// torque_oscillation_deadzone_guard_core
// torque pass-through with a zero-torque hold when the torque oscillates
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------------------
//  req     | in  | valid / ready | torque_in, yaw_command, launch_command,
//          |     |               | command_invalid
//  rsp     | out | valid / ready | torque_out, hold_active, oscillation_found
//  cfg     | in  | cfg_we        | cfg_index, cfg_data (no read-back)
//
//  an invalid or hold item passes from the accept through the evaluate and
//  finish states into the output register; a pass-through item also spends
//  one full rotation of the sample chain past the scan unit in the scan state.
//  one item is in work at a time; the next item is taken the cycle after a
//  result is loaded into the output register.
//  reset clears the window, the hold state and the registers to their defaults.
//  a stalled result holds in the output register while the next item runs;
//  a finished item waits only if that register is still full.
// ----------------------------------------------------------------------------
module torque_oscillation_deadzone_guard_core #(
	parameter int WINDOW = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tdg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tdg_pkg::CFG_W-1:0]      cfg_data,
	tdg_in_if.sink                         req,
	tdg_out_if.source                      rsp
);

	localparam int CW = $clog2(WINDOW);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] amp_thr_q;
	logic [5:0]  sc_min_q;
	logic [15:0] hold_ticks_q;
	logic [30:0] cmd_thr_q;

	// item register
	tdg_pkg::sample_t   torque_q;
	logic signed [31:0] yaw_q;
	logic signed [31:0] launch_q;
	logic               invalid_q;

	// guard state
	logic signed [31:0] last_yaw_q;
	logic signed [31:0] last_launch_q;
	logic               hold_q;
	logic               timer_q;
	logic [15:0]        elapsed_q;
	tdg_pkg::sample_t   last_torque_q;

	// result of a non-scanning item, and scan bookkeeping
	logic               pass_q;
	tdg_pkg::sample_t   res_torque_q;
	logic               res_hold_q;
	logic [CW-1:0]      scan_cnt_q;

	// output register
	logic               out_valid_q;
	tdg_pkg::sample_t   out_torque_q;
	logic               out_hold_q;
	logic               out_found_q;

	// chain
	tdg_pkg::sample_t   sample_w [WINDOW];
	logic               chain_shift;
	logic               chain_rotate;
	logic               chain_en;
	tdg_pkg::sample_t   tail_nbr;

	// scan unit
	tdg_pkg::scan_ctl_t scan_ctl;
	logic [CW-1:0]      scan_changes;
	logic [16:0]        scan_spread;
	logic               osc;

	// setpoint change test
	logic signed [32:0] d_yaw;
	logic signed [32:0] d_launch;
	logic [32:0]        a_yaw;
	logic [32:0]        a_launch;
	logic               fresh;
	logic [15:0]        elapsed_inc;
	logic               hold_end;

	logic               out_free;
	logic               out_load;
	logic               in_acc;

	assign in_acc   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign out_load = (state_q == ST_FIN) && out_free;

	assign req.ready             = (state_q == ST_IDLE);
	assign rsp.valid             = out_valid_q;
	assign rsp.torque_out        = out_torque_q;
	assign rsp.hold_active       = out_hold_q;
	assign rsp.oscillation_found = out_found_q;

	// change larger than threshold on either setpoint, exact in 33 bits
	assign d_yaw    = {yaw_q[31], yaw_q} - {last_yaw_q[31], last_yaw_q};
	assign d_launch = {launch_q[31], launch_q} - {last_launch_q[31], last_launch_q};
	assign a_yaw    = d_yaw[32] ? 33'(-d_yaw) : 33'(d_yaw);
	assign a_launch = d_launch[32] ? 33'(-d_launch) : 33'(d_launch);
	assign fresh    = (a_yaw > {2'b00, cmd_thr_q}) || (a_launch > {2'b00, cmd_thr_q});

	// hold counter saturates at all ones
	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	// the running hold runs out on this tick
	assign hold_end    = timer_q && (elapsed_inc >= hold_ticks_q);

	// window: shift in a new sample, or rotate once around during the scan
	assign chain_shift  = (state_q == ST_EVAL) && !invalid_q && !(hold_q && !fresh);
	assign chain_rotate = (state_q == ST_SCAN);
	assign chain_en     = chain_shift || chain_rotate;
	assign tail_nbr     = chain_shift ? torque_q : sample_w[0];

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW; gi++) begin : g_cell
			if (gi == WINDOW - 1) begin : g_tail
				tdg_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.en     (chain_en),
					.nbr    (tail_nbr),
					.sample (sample_w[gi])
				);
			end else begin : g_body
				tdg_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.en     (chain_en),
					.nbr    (sample_w[gi+1]),
					.sample (sample_w[gi])
				);
			end
		end
	endgenerate

	// the head sees the oldest sample first, then each newer one in turn
	assign scan_ctl.init = (state_q == ST_SCAN) && (scan_cnt_q == '0);
	assign scan_ctl.step = (state_q == ST_SCAN) && (scan_cnt_q != '0);

	tdg_scan #(
		.WINDOW (WINDOW)
	) u_scan (
		.clk     (clk),
		.ctl     (scan_ctl),
		.head    (sample_w[0]),
		.changes (scan_changes),
		.spread  (scan_spread)
	);

	assign osc = (7'(scan_changes) >= {1'b0, sc_min_q}) &&
		(scan_spread > {1'b0, amp_thr_q});

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_thr_q    <= tdg_pkg::AMP_THR_RST;
			sc_min_q     <= tdg_pkg::SC_MIN_RST;
			hold_ticks_q <= tdg_pkg::HOLD_RST;
			cmd_thr_q    <= tdg_pkg::CMD_THR_RST;
		end else if (cfg_we) begin
			case (tdg_pkg::cfg_idx_t'(cfg_index))
				tdg_pkg::CFG_AMPLITUDE_THRESHOLD:      amp_thr_q    <= cfg_data[15:0];
				tdg_pkg::CFG_SIGN_CHANGE_MIN:          sc_min_q     <= cfg_data[5:0];
				tdg_pkg::CFG_HOLD_TICKS:               hold_ticks_q <= cfg_data[15:0];
				tdg_pkg::CFG_COMMAND_CHANGE_THRESHOLD: cmd_thr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// item capture, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			torque_q  <= req.torque_in;
			yaw_q     <= req.yaw_command;
			launch_q  <= req.launch_command;
			invalid_q <= req.command_invalid;
		end
	end

	// sequencer and guard state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			last_yaw_q    <= '0;
			last_launch_q <= '0;
			hold_q        <= 1'b0;
			timer_q       <= 1'b0;
			elapsed_q     <= '0;
			last_torque_q <= '0;
			pass_q        <= 1'b0;
			res_torque_q  <= '0;
			res_hold_q    <= 1'b0;
			scan_cnt_q    <= '0;
			out_valid_q   <= 1'b0;
			out_torque_q  <= '0;
			out_hold_q    <= 1'b0;
			out_found_q   <= 1'b0;
		end else begin
			// a new result wins over the one leaving at this edge
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (invalid_q) begin
						// skipped tick: repeat last result, nothing changes
						pass_q       <= 1'b0;
						res_torque_q <= last_torque_q;
						res_hold_q   <= hold_q;
						state_q      <= ST_FIN;
					end else begin
						last_yaw_q    <= yaw_q;
						last_launch_q <= launch_q;
						if (hold_q && !fresh) begin
							// hold tick, torque forced to zero
							last_torque_q <= '0;
							pass_q        <= 1'b0;
							res_torque_q  <= '0;
							res_hold_q    <= !hold_end;
							if (timer_q) begin
								elapsed_q <= elapsed_inc;
							end
							if (hold_end) begin
								hold_q  <= 1'b0;
								timer_q <= 1'b0;
							end
							state_q <= ST_FIN;
						end else begin
							// pass-through, a setpoint change cancels the hold
							if (hold_q) begin
								hold_q    <= 1'b0;
								timer_q   <= 1'b0;
								elapsed_q <= '0;
							end
							last_torque_q <= torque_q;
							pass_q        <= 1'b1;
							scan_cnt_q    <= '0;
							state_q       <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + CW'(1);
					if (scan_cnt_q == CW'(WINDOW - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						if (pass_q) begin
							out_torque_q <= osc ? '0 : torque_q;
							out_hold_q   <= osc;
							out_found_q  <= osc;
							if (osc) begin
								hold_q        <= 1'b1;
								timer_q       <= 1'b1;
								elapsed_q     <= '0;
								last_torque_q <= '0;
							end
						end else begin
							out_torque_q <= res_torque_q;
							out_hold_q   <= res_hold_q;
							out_found_q  <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/tdg_checker.sv
// ----------------------------------------------------------------------------
// tdg_checker
// port-level checks of the torque oscillation guard
// ----------------------------------------------------------------------------
module tdg_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input tdg_pkg::sample_t rsp_torque_out,
	input logic             rsp_hold_active,
	input logic             rsp_oscillation_found
);

	// a stalled result keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_torque_out) &&
		$stable(rsp_hold_active) && $stable(rsp_oscillation_found))
		else $error("stalled result changed");

	// a detection always starts a hold
	a_found_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_oscillation_found |-> rsp_hold_active)
		else $error("oscillation found without hold");

	// no torque reaches the motor while the hold is in force
	a_hold_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_hold_active |-> rsp_torque_out == '0)
		else $error("torque during hold");

	// one item at a time: no second item right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted while busy");

endmodule

bind torque_oscillation_deadzone_guard_core tdg_checker u_tdg_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.req_valid             (req.valid),
	.req_ready             (req.ready),
	.rsp_valid             (rsp.valid),
	.rsp_ready             (rsp.ready),
	.rsp_torque_out        (rsp.torque_out),
	.rsp_hold_active       (rsp.hold_active),
	.rsp_oscillation_found (rsp.oscillation_found)
);

>>> sim/tdg_guard_checker.sv
// ----------------------------------------------------------------------------
// tdg_guard_checker
// watches the command and torque channels, predicts each torque item and
// compares it field by field with what the guard sends out
// ----------------------------------------------------------------------------
module tdg_guard_checker #(
	parameter int WINDOW = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tdg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tdg_pkg::CFG_W-1:0]      cfg_data,
	tdg_in_if                              req,
	tdg_out_if                             rsp,
	output int                             fails,
	output int                             pending
);

	typedef struct packed {
		tdg_pkg::sample_t torque_out;
		logic             hold_active;
		logic             oscillation_found;
	} guard_result_t;

	// predictor copy of the guard state
	tdg_pkg::sample_t   samples [WINDOW];
	logic signed [31:0] prev_yaw;
	logic signed [31:0] prev_launch;
	logic               hold_on;
	logic               timer_on;
	logic [15:0]        elapsed;
	tdg_pkg::sample_t   prev_torque;

	// predictor copy of the registers
	logic [15:0]        amp_thr;
	logic [5:0]         sc_min;
	logic [15:0]        hold_len;
	logic [30:0]        cmd_thr;

	guard_result_t      expected_torque_q [$];
	int                 err_count;

	function automatic logic setpoint_moved(logic signed [31:0] now, logic signed [31:0] old);
		longint d;
		d = longint'(now) - longint'(old);
		if (d < 0)
			d = -d;
		return d > longint'({33'd0, cmd_thr});
	endfunction

	function automatic logic window_oscillates();
		int changes;
		int lo;
		int hi;
		changes = 0;
		lo = samples[0];
		hi = samples[0];
		for (int i = 1; i < WINDOW; i++) begin
			// zero never counts as either sign
			if ((samples[i-1] < 0 && samples[i] > 0) || (samples[i-1] > 0 && samples[i] < 0))
				changes++;
			if (samples[i] < lo)
				lo = samples[i];
			if (samples[i] > hi)
				hi = samples[i];
		end
		return (changes >= int'(sc_min)) && ((hi - lo) > int'(amp_thr));
	endfunction

	function automatic guard_result_t guard_tick(tdg_pkg::sample_t t, logic signed [31:0] y,
			logic signed [31:0] l, logic inv);
		guard_result_t r;
		logic          found;
		logic          fresh;
		found = 1'b0;
		if (!inv) begin
			fresh = setpoint_moved(y, prev_yaw) || setpoint_moved(l, prev_launch);
			prev_yaw = y;
			prev_launch = l;
			if (fresh && hold_on) begin
				hold_on = 1'b0;
				timer_on = 1'b0;
				elapsed = '0;
			end
			if (hold_on) begin
				prev_torque = '0;
				if (timer_on) begin
					if (elapsed != 16'hFFFF)
						elapsed++;
					if (elapsed >= hold_len) begin
						hold_on = 1'b0;
						timer_on = 1'b0;
					end
				end
			end else begin
				prev_torque = t;
				for (int i = 0; i < WINDOW - 1; i++)
					samples[i] = samples[i+1];
				samples[WINDOW-1] = t;
				if (window_oscillates()) begin
					found = 1'b1;
					hold_on = 1'b1;
					timer_on = 1'b1;
					elapsed = '0;
					prev_torque = '0;
				end
			end
		end
		r.torque_out = prev_torque;
		r.hold_active = hold_on;
		r.oscillation_found = found;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		guard_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++)
				samples[i] = '0;
			prev_yaw = '0;
			prev_launch = '0;
			hold_on = 1'b0;
			timer_on = 1'b0;
			elapsed = '0;
			prev_torque = '0;
			amp_thr = tdg_pkg::AMP_THR_RST;
			sc_min = tdg_pkg::SC_MIN_RST;
			hold_len = tdg_pkg::HOLD_RST;
			cmd_thr = tdg_pkg::CMD_THR_RST;
			expected_torque_q.delete();
			err_count = 0;
			fails <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (tdg_pkg::cfg_idx_t'(cfg_index))
					tdg_pkg::CFG_AMPLITUDE_THRESHOLD:      amp_thr = cfg_data[15:0];
					tdg_pkg::CFG_SIGN_CHANGE_MIN:          sc_min = cfg_data[5:0];
					tdg_pkg::CFG_HOLD_TICKS:               hold_len = cfg_data[15:0];
					tdg_pkg::CFG_COMMAND_CHANGE_THRESHOLD: cmd_thr = cfg_data[30:0];
					default: ;
				endcase
			end
			// results first: an item taken at this edge cannot answer yet
			if (rsp.valid && rsp.ready) begin
				if (expected_torque_q.size() == 0) begin
					err_count++;
					$error("torque item with none expected: torque_out %0d", rsp.torque_out);
				end else begin
					want = expected_torque_q.pop_front();
					if (rsp.torque_out !== want.torque_out) begin
						err_count++;
						$error("torque_out expected %0d actual %0d",
							want.torque_out, rsp.torque_out);
					end
					if (rsp.hold_active !== want.hold_active) begin
						err_count++;
						$error("hold_active expected %0d actual %0d",
							want.hold_active, rsp.hold_active);
					end
					if (rsp.oscillation_found !== want.oscillation_found) begin
						err_count++;
						$error("oscillation_found expected %0d actual %0d",
							want.oscillation_found, rsp.oscillation_found);
					end
				end
			end
			if (req.valid && req.ready)
				expected_torque_q.insert(expected_torque_q.size(),
					guard_tick(req.torque_in, req.yaw_command,
					req.launch_command, req.command_invalid));
			fails <= err_count;
			pending <= expected_torque_q.size();
		end
	end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives command items into the torque oscillation guard under several
// register settings and lets the checker compare every torque item
// ----------------------------------------------------------------------------
module tb;

	localparam int WINDOW      = 16;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int BACKLOG_LEN = 300;

	// receiver stall styles
	typedef enum int {
		RX_OPEN,
		RX_MOSTLY,
		RX_SPARSE,
		RX_PATTERN
	} rx_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [tdg_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tdg_pkg::CFG_W-1:0]      cfg_data;

	tdg_in_if  req_ch ();
	tdg_out_if rsp_ch ();

	int fails;
	int pending;
	int cycle_count = 0;
	int burst_left = 1;
	int backlog_req = 0;
	int backlog_done = 0;

	// last setpoints the guard accepted and the register values now in force
	logic signed [31:0] cur_yaw;
	logic signed [31:0] cur_launch;
	int unsigned        cur_amp;
	int unsigned        cur_hold;
	int unsigned        cur_thr;

	torque_oscillation_deadzone_guard_core #(
		.WINDOW(WINDOW)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	tdg_guard_checker #(
		.WINDOW(WINDOW)
	) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.fails     (fails),
		.pending   (pending)
	);

	always #4 clk = ~clk;

	// hard stop in case the guard hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: stall styles in segments, plus a long hold-off on request so
	// the output register and the item in work back up into the input
	initial begin
		int       hold_left;
		int       seg_left;
		rx_mode_t mode;
		hold_left = 0;
		seg_left = 0;
		mode = RX_OPEN;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (backlog_done < backlog_req) begin
				backlog_done++;
				hold_left = BACKLOG_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					seg_left = $urandom_range(20, 200);
				end
				seg_left--;
				case (mode)
					RX_OPEN:   rsp_ch.ready <= 1'b1;
					RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default:   rsp_ch.ready <= ((seg_left % 7) < 3);
				endcase
			end
		end
	end

	// one item, then maybe a gap once the burst is used up; valid stays high
	// across back-to-back items
	task automatic send_cmd(input tdg_pkg::sample_t t, input logic signed [31:0] y,
			input logic signed [31:0] l, input logic inv);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.torque_in <= t;
		req_ch.yaw_command <= y;
		req_ch.launch_command <= l;
		req_ch.command_invalid <= inv;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (!inv) begin
			cur_yaw = y;
			cur_launch = l;
		end
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// small setpoint wobble that stays within the change threshold
	function automatic logic signed [31:0] nudge(logic signed [31:0] v);
		longint r;
		int unsigned d;
		if (cur_thr == 0)
			return v;
		d = $urandom_range(0, (cur_thr < 1000) ? cur_thr : 1000);
		r = $urandom_range(0, 1) ? longint'(v) + d : longint'(v) - d;
		if (r > 64'sd2147483647 || r < -64'sd2147483648)
			return v;
		return r[31:0];
	endfunction

	task automatic send_steady(input tdg_pkg::sample_t t);
		send_cmd(t, nudge(cur_yaw), nudge(cur_launch), 1'b0);
	endtask

	task automatic send_invalid();
		send_cmd(tdg_pkg::sample_t'($urandom), $urandom, $urandom, 1'b1);
	endtask

	// setpoint jump large enough for any threshold, or a fully random one
	task automatic send_jump(input tdg_pkg::sample_t t);
		logic signed [31:0] y;
		logic signed [31:0] l;
		y = cur_yaw;
		l = cur_launch;
		case ($urandom_range(0, 2))
			0: y = (cur_yaw >= 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
			1: l = (cur_launch >= 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
			default: begin
				y = $urandom;
				l = $urandom;
			end
		endcase
		send_cmd(t, y, l, 1'b0);
	endtask

	// all four registers, with junk above the narrow ones
	task automatic write_settings(input int unsigned amp, input int unsigned sc,
			input int unsigned hold, input int unsigned thr);
		logic [tdg_pkg::CFG_W-1:0] d;
		cfg_we <= 1'b1;
		cfg_index <= tdg_pkg::CFG_AMPLITUDE_THRESHOLD;
		d = tdg_pkg::CFG_W'($urandom);
		d[15:0] = amp[15:0];
		cfg_data <= d;
		@(posedge clk);
		cfg_index <= tdg_pkg::CFG_SIGN_CHANGE_MIN;
		d = tdg_pkg::CFG_W'($urandom);
		d[5:0] = sc[5:0];
		cfg_data <= d;
		@(posedge clk);
		cfg_index <= tdg_pkg::CFG_HOLD_TICKS;
		d = tdg_pkg::CFG_W'($urandom);
		d[15:0] = hold[15:0];
		cfg_data <= d;
		@(posedge clk);
		cfg_index <= tdg_pkg::CFG_COMMAND_CHANGE_THRESHOLD;
		cfg_data <= thr[30:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_amp = amp & 32'hFFFF;
		cur_hold = hold & 32'hFFFF;
		cur_thr = thr & 32'h7FFFFFFF;
	endtask

	// stop offering and wait until every torque item has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// mostly alternating trains that can trip the detector, hold ride-outs
	// that may end in a cancel, and some plain noise
	task automatic run_phase(input int budget);
		int               sent;
		int               kind;
		int               len;
		int               pick;
		int unsigned      mmin;
		int unsigned      m;
		logic             pos;
		tdg_pkg::sample_t t;
		sent = 0;
		while (sent < budget) begin
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				len = $urandom_range(4, WINDOW + 4);
				// each half of the swing above half the threshold
				mmin = cur_amp / 2 + 1;
				if (mmin > 32767)
					mmin = 32767;
				pos = $urandom_range(0, 1);
				repeat (len) begin
					m = $urandom_range(mmin, 32767);
					pick = $urandom_range(0, 19);
					if (pick == 0)
						t = '0;
					else if (pos)
						t = tdg_pkg::sample_t'(m);
					else
						t = tdg_pkg::sample_t'(-int'(m) - int'($urandom_range(0, 1)));
					if (pick == 1)
						send_invalid();
					else
						send_steady(t);
					// now and then keep the sign to break the run
					if (pick != 2)
						pos = !pos;
				end
			end else if (kind < 75) begin
				len = $urandom_range(1, 40);
				repeat (len) begin
					if ($urandom_range(0, 15) == 0)
						send_invalid();
					else
						send_steady(tdg_pkg::sample_t'($urandom));
				end
				// long holds mostly get cancelled, short ones run out
				if ($urandom_range(0, 99) < ((cur_hold > 60) ? 80 : 30))
					send_jump(tdg_pkg::sample_t'($urandom));
			end else begin
				len = $urandom_range(1, 10);
				repeat (len) begin
					if ($urandom_range(0, 6) == 0)
						send_invalid();
					else if ($urandom_range(0, 2) == 0)
						send_cmd(tdg_pkg::sample_t'($urandom), $urandom, $urandom, 1'b0);
					else
						send_steady(tdg_pkg::sample_t'($urandom));
				end
			end
			sent += len;
		end
	endtask

	initial begin
		int unsigned amp;
		int unsigned sc;
		int unsigned hold;
		int unsigned thr;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= tdg_pkg::CFG_AMPLITUDE_THRESHOLD;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.torque_in <= '0;
		req_ch.yaw_command <= '0;
		req_ch.launch_command <= '0;
		req_ch.command_invalid <= 1'b0;
		cur_yaw = '0;
		cur_launch = '0;
		cur_amp = tdg_pkg::AMP_THR_RST;
		cur_hold = tdg_pkg::HOLD_RST;
		cur_thr = tdg_pkg::CMD_THR_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset defaults
		// torque extremes pass straight through
		send_cmd(16'sh7FFF, 32'sd0, 32'sd0, 1'b0);
		send_cmd(16'sh8000, 32'sd0, 32'sd0, 1'b0);
		// invalid item repeats the last torque and leaves the setpoints alone
		send_cmd(16'sh1234, 32'sh80000000, 32'sh7FFFFFFF, 1'b1);
		// setpoint extremes with no hold running change nothing visible
		send_cmd(16'sh0000, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
		send_cmd(16'sh0000, 32'sh7FFFFFFF, 32'sh80000000, 1'b0);
		// a full window of alternating swings trips the detector on the last one
		for (int i = 0; i < WINDOW; i++)
			send_cmd((i % 2) ? -16'sd3000 : 16'sd3000, cur_yaw, cur_launch, 1'b0);
		// hold tick, invalid item during the hold, then a cancel by a full-scale jump
		send_cmd(16'sd1000, cur_yaw, cur_launch, 1'b0);
		send_invalid();
		send_cmd(16'sd100, 32'sh80000000, cur_launch, 1'b0);

		// random part, reset defaults, with a long output stall early on
		backlog_req++;
		run_phase(180);

		// every register at its minimum
		wait_drained();
		write_settings(0, 0, 0, 0);
		run_phase(180);

		// every register at its maximum
		wait_drained();
		write_settings(32'hFFFF, 32'h3F, 32'hFFFF, 32'h7FFFFFFF);
		run_phase(120);

		// mixed settings, mostly ones where holds start and end often
		for (int p = 0; p < 7; p++) begin
			wait_drained();
			case ($urandom_range(0, 2))
				0:       amp = 0;
				1:       amp = $urandom_range(0, 4000);
				default: amp = $urandom_range(0, 65535);
			endcase
			sc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
			hold = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 30) : $urandom_range(0, 65535);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: thr = $urandom_range(0, 2000);
				4, 5, 6:    thr = $urandom & 32'h7FFFFFFF;
				default:    thr = 0;
			endcase
			write_settings(amp, sc, hold, thr);
			if (p == 3)
				backlog_req++;
			run_phase(150);
		end

		// drain, then let the pipeline settle before the verdict
		wait_drained();
		repeat (WINDOW + 8) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
